// File: hdl/pimpp_pkg.sv
package pimpp_pkg;

    // Port widths fixed by the pixel and byte formats
    localparam int PIXEL_WIDTH = 24;
    localparam int INK_WIDTH   = 4;
    localparam int COUNT_WIDTH = 5;
    localparam int BYTE_WIDTH  = 8;

    typedef logic [INK_WIDTH-1:0]   ink_t;
    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [BYTE_WIDTH-1:0]  screen_byte_t;

    // Result of one palette lookup for a pixel pair
    typedef struct packed {
        ink_t   left_ink;
        ink_t   right_ink;
        logic   overflow;
        count_t colors_used;
    } lookup_t;

endpackage

// File: hdl/pimpp_palette.sv
module pimpp_palette #(
    parameter int PALETTE_DEPTH = 16,
    parameter int KEY_WIDTH     = 24
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  logic [KEY_WIDTH-1:0] left_key,
    input  logic [KEY_WIDTH-1:0] right_key,
    output pimpp_pkg::lookup_t   lookup
);

    localparam int CW    = $clog2(PALETTE_DEPTH + 1);
    localparam int INK_W = pimpp_pkg::INK_WIDTH;
    localparam int CNT_W = pimpp_pkg::COUNT_WIDTH;

    logic [KEY_WIDTH-1:0] colors_reg [PALETTE_DEPTH];
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_mid;
    logic [CW-1:0]        count_next;

    logic          left_hit;
    logic          right_hit;
    logic [CW-1:0] left_idx;
    logic [CW-1:0] right_idx;
    logic          same_color;
    logic          left_add;
    logic          left_ovf;
    logic          right_add;
    logic          right_ovf;
    logic [CW-1:0] left_sel;
    logic [CW-1:0] right_sel;

    // Entries are unique, so OR the matching indices together
    always_comb
    begin
        left_hit  = 1'b0;
        right_hit = 1'b0;
        left_idx  = '0;
        right_idx = '0;
        for (int i = 0; i < PALETTE_DEPTH; i++)
        begin
            if (CW'(i) < count_reg && colors_reg[i] == left_key)
            begin
                left_hit = 1'b1;
                left_idx = left_idx | CW'(i);
            end
            if (CW'(i) < count_reg && colors_reg[i] == right_key)
            begin
                right_hit = 1'b1;
                right_idx = right_idx | CW'(i);
            end
        end
    end

    always_comb
    begin
        same_color = (left_key == right_key);

        left_add  = !left_hit && (count_reg < CW'(PALETTE_DEPTH));
        left_ovf  = !left_hit && !(count_reg < CW'(PALETTE_DEPTH));
        count_mid = count_reg + CW'(left_add);
        left_sel  = left_hit ? left_idx : (left_add ? count_reg : '0);

        // Right pixel sees the entry the left pixel may have just added
        if (same_color)
        begin
            right_add = 1'b0;
            right_ovf = left_ovf;
            right_sel = left_sel;
        end
        else
        begin
            right_add = !right_hit && (count_mid < CW'(PALETTE_DEPTH));
            right_ovf = !right_hit && !(count_mid < CW'(PALETTE_DEPTH));
            right_sel = right_hit ? right_idx : (right_add ? count_mid : '0);
        end

        count_next = count_mid + CW'(right_add);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (load)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < PALETTE_DEPTH; i++)
        begin
            if (load && left_add && count_reg == CW'(i))
            begin
                colors_reg[i] <= left_key;
            end
            else if (load && right_add && count_mid == CW'(i))
            begin
                colors_reg[i] <= right_key;
            end
        end
    end

    always_comb
    begin
        lookup.left_ink    = INK_W'(left_sel);
        lookup.right_ink   = INK_W'(right_sel);
        lookup.overflow    = left_ovf || right_ovf;
        lookup.colors_used = CNT_W'(count_next);
    end

endmodule

// File: hdl/palette_index_mode0_pixel_packer.sv
// Pixel pair to mode-0 screen byte packer.
//
// Input channel: in_valid / in_stall carry one word of two pixel colors,
// left_color then right_color. Each color is looked up in a palette that
// grows in order of first appearance (up to PALETTE_DEPTH colors); a new
// color is appended, and a new color arriving when the palette is full
// gets ink 0 and raises palette_overflow for that word.
// Output channel: out_valid / out_stall carry screen_byte, palette_overflow
// and colors_used (palette entries filled after this word).
// The accepted word sits in the input register, then the PALETTE_DEPTH-way
// parallel compare and append logic feeds the output register once the
// output can advance. Throughput is one word per cycle unless out_stall
// holds a waiting result.
// When out_stall holds a waiting result, the input register still takes
// one more word; in_stall rises only once both registers are full.
// Reset empties the palette and both pipeline registers; stored colors
// need no clearing since only filled entries are ever compared.
module palette_index_mode0_pixel_packer #(
    parameter int PALETTE_DEPTH = 16,
    parameter int COLOR_WIDTH   = 24
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [pimpp_pkg::PIXEL_WIDTH-1:0] left_color,
    input  logic [pimpp_pkg::PIXEL_WIDTH-1:0] right_color,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [pimpp_pkg::BYTE_WIDTH-1:0]  screen_byte,
    output logic                              palette_overflow,
    output logic [pimpp_pkg::COUNT_WIDTH-1:0] colors_used
);

    localparam int KEY_WIDTH = (COLOR_WIDTH < pimpp_pkg::PIXEL_WIDTH) ?
                               COLOR_WIDTH : pimpp_pkg::PIXEL_WIDTH;

    logic                  in_valid_reg;
    logic [KEY_WIDTH-1:0]  left_reg;
    logic [KEY_WIDTH-1:0]  right_reg;
    logic                  out_valid_reg;
    pimpp_pkg::screen_byte_t byte_reg;
    pimpp_pkg::screen_byte_t byte_next;
    logic                  overflow_reg;
    pimpp_pkg::count_t     used_reg;

    logic                  advance;
    logic                  in_take;
    logic                  fire;
    pimpp_pkg::lookup_t    lookup;

    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;
    assign fire     = in_valid_reg && advance;

    pimpp_palette #(
        .PALETTE_DEPTH (PALETTE_DEPTH),
        .KEY_WIDTH     (KEY_WIDTH)
    ) u_palette (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire),
        .left_key  (left_reg),
        .right_key (right_reg),
        .lookup    (lookup)
    );

    // Interleave: left ink bits 0..3 to byte bits 7,3,5,1; right to 6,2,4,0
    always_comb
    begin
        byte_next[7] = lookup.left_ink[0];
        byte_next[3] = lookup.left_ink[1];
        byte_next[5] = lookup.left_ink[2];
        byte_next[1] = lookup.left_ink[3];
        byte_next[6] = lookup.right_ink[0];
        byte_next[2] = lookup.right_ink[1];
        byte_next[4] = lookup.right_ink[2];
        byte_next[0] = lookup.right_ink[3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            left_reg  <= left_color[KEY_WIDTH-1:0];
            right_reg <= right_color[KEY_WIDTH-1:0];
        end
        if (fire)
        begin
            byte_reg     <= byte_next;
            overflow_reg <= lookup.overflow;
            used_reg     <= lookup.colors_used;
        end
    end

    assign out_valid        = out_valid_reg;
    assign screen_byte      = byte_reg;
    assign palette_overflow = overflow_reg;
    assign colors_used      = used_reg;

endmodule

// File: hdl/pimpp_checker.sv
module pimpp_checker #(
    parameter int PALETTE_DEPTH = 16
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_stall,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic [pimpp_pkg::BYTE_WIDTH-1:0]  screen_byte,
    input logic                              palette_overflow,
    input logic [pimpp_pkg::COUNT_WIDTH-1:0] colors_used
);

    localparam int CNT_W = pimpp_pkg::COUNT_WIDTH;

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(screen_byte)
            && $stable(palette_overflow) && $stable(colors_used))
    else $error("stalled result changed");

    // Input backs up only behind a stalled, full output
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

    // Overflow only happens with a full palette
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && palette_overflow |-> colors_used == CNT_W'(PALETTE_DEPTH))
    else $error("overflow reported with room left");

    // Every word leaves at least one color in the palette
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> colors_used != '0 && colors_used <= CNT_W'(PALETTE_DEPTH))
    else $error("colors_used out of range");

endmodule

bind palette_index_mode0_pixel_packer pimpp_checker #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
) u_pimpp_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_stall         (in_stall),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .screen_byte      (screen_byte),
    .palette_overflow (palette_overflow),
    .colors_used      (colors_used)
);
